@@ rtl/lev_pkg.sv @@
// Shared types, constants and register indexes of the Levenshtein row update block.
`default_nettype none

package lev_pkg;

	localparam int DEF_MAX_B_LEN = 16;
	localparam int DEF_CELL_BITS = 16;

	localparam int CHAR_BITS     = 8;
	localparam int NUM_B_CHARS   = 16;
	localparam int DIST_BITS     = 16;
	localparam int LEN_BITS      = 5;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_IDX_BITS  = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_B_LENGTH     = 2'd0,
		REG_B_CHARS_LOW  = 2'd1,
		REG_B_CHARS_HIGH = 2'd2
	} lev_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} lev_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic load_out;
	} lev_cmd_t;

	typedef struct packed {
		logic last;
	} lev_sts_t;

endpackage

`default_nettype wire

@@ rtl/lev_in_if.sv @@
// Input channel carrying one character of string A per transfer.
`default_nettype none

interface lev_in_if;
	import lev_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CHAR_BITS-1:0] a_char;

	modport source (output valid, output a_char, input ready);
	modport sink (input valid, input a_char, output ready);
endinterface

`default_nettype wire

@@ rtl/lev_out_if.sv @@
// Output channel carrying the edit distance and saturation flag per transfer.
`default_nettype none

interface lev_out_if;
	import lev_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [DIST_BITS-1:0] distance;
	logic                 saturated;

	modport source (output valid, output distance, output saturated, input ready);
	modport sink (input valid, input distance, input saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/lev_ctrl.sv @@
// Controller state machine sequencing the row sweep and the output register.
`default_nettype none

module lev_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire lev_pkg::lev_sts_t sts,
	output lev_pkg::lev_cmd_t      cmd
);
	import lev_pkg::*;

	lev_state_t state_q;
	lev_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sts.last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SWEEP: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/lev_dpath.sv @@
// Datapath: configuration registers, row memory, cell update and output register.
`default_nettype none

module lev_dpath #(
	parameter int MAX_B_LEN = lev_pkg::DEF_MAX_B_LEN,
	parameter int CELL_BITS = lev_pkg::DEF_CELL_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [lev_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [lev_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic [lev_pkg::CHAR_BITS-1:0]     a_char,
	input  wire lev_pkg::lev_cmd_t                 cmd,
	output lev_pkg::lev_sts_t                      sts,
	output logic [lev_pkg::DIST_BITS-1:0]          distance,
	output logic                                   saturated
);
	import lev_pkg::*;

	localparam int ROW_DEPTH = MAX_B_LEN + 1;
	localparam int IDX_W     = $clog2(ROW_DEPTH);
	localparam int POS_W     = (IDX_W > 4) ? IDX_W : 4;
	localparam int WIDE_W    = (CELL_BITS > DIST_BITS) ? CELL_BITS : DIST_BITS;
	localparam logic [CELL_BITS-1:0] CELL_MAX = {CELL_BITS{1'b1}};

	logic [LEN_BITS-1:0]      b_length_q;
	logic [CFG_DATA_BITS-1:0] b_chars_low_q;
	logic [CFG_DATA_BITS-1:0] b_chars_high_q;

	logic [CELL_BITS-1:0] mem [ROW_DEPTH];
	logic [ROW_DEPTH-1:0] cell_vld_q;
	logic [CELL_BITS-1:0] rdata_q;
	logic                 rvld_q;

	logic [CHAR_BITS-1:0] a_q;
	logic [IDX_W-1:0]     len_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CELL_BITS-1:0] left_q;
	logic [CELL_BITS-1:0] diag_q;
	logic                 sat_q;
	logic [DIST_BITS-1:0] distance_q;
	logic                 saturated_q;

	logic [CHAR_BITS-1:0] b_bytes [NUM_B_CHARS];
	logic [IDX_W-1:0]     len_clamped;
	logic [IDX_W-1:0]     pos;
	logic [POS_W-1:0]     pos_w;
	logic [CHAR_BITS-1:0] b_char;
	logic                 cost;
	logic [CELL_BITS-1:0] above;
	logic [CELL_BITS-1:0] left_inc;
	logic [CELL_BITS-1:0] diag_add;
	logic [CELL_BITS-1:0] above_inc;
	logic [CELL_BITS-1:0] min_a;
	logic [CELL_BITS-1:0] cell_new;
	logic                 last;
	logic                 re;
	logic [IDX_W-1:0]     raddr;
	logic                 len_write;
	logic [WIDE_W-1:0]    left_wide;

	always_comb begin
		for (int k = 0; k < NUM_B_CHARS / 2; k++) begin
			b_bytes[k]                   = b_chars_low_q[k*CHAR_BITS +: CHAR_BITS];
			b_bytes[k + NUM_B_CHARS / 2] = b_chars_high_q[k*CHAR_BITS +: CHAR_BITS];
		end
	end

	always_comb begin
		if (32'(b_length_q) > MAX_B_LEN) begin
			len_clamped = IDX_W'(MAX_B_LEN);
		end else begin
			len_clamped = IDX_W'(b_length_q);
		end
	end

	assign len_write = cfg_we && (cfg_index == REG_B_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_length_q     <= '0;
			b_chars_low_q  <= '0;
			b_chars_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_B_LENGTH:     b_length_q     <= cfg_data[LEN_BITS-1:0];
				REG_B_CHARS_LOW:  b_chars_low_q  <= cfg_data;
				REG_B_CHARS_HIGH: b_chars_high_q <= cfg_data;
				default:          b_length_q     <= b_length_q;
			endcase
		end
	end

	// A cell whose valid bit is clear still holds its initial value, its own index.
	assign above = rvld_q ? rdata_q : CELL_BITS'(idx_q);

	assign pos    = idx_q - 1'b1;
	assign pos_w  = POS_W'(pos);
	assign b_char = ((pos_w >> 4) == '0) ? b_bytes[pos_w[3:0]] : '0;
	assign cost   = (b_char != a_q);

	assign left_inc  = (left_q == CELL_MAX) ? CELL_MAX : left_q + 1'b1;
	assign above_inc = (above == CELL_MAX) ? CELL_MAX : above + 1'b1;
	assign diag_add  = (diag_q == CELL_MAX) ? CELL_MAX : diag_q + CELL_BITS'(cost);
	assign min_a     = (left_inc < diag_add) ? left_inc : diag_add;

	always_comb begin
		if (idx_q == '0) begin
			cell_new = above_inc;
		end else begin
			cell_new = (min_a < above_inc) ? min_a : above_inc;
		end
	end

	assign last     = (idx_q == len_q);
	assign sts.last = last;

	always_comb begin
		re    = 1'b0;
		raddr = '0;
		if (cmd.start) begin
			re = 1'b1;
		end else if (cmd.step && !last) begin
			re    = 1'b1;
			raddr = idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			mem[idx_q] <= cell_new;
		end
		if (re) begin
			rdata_q <= mem[raddr];
			rvld_q  <= cell_vld_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= '0;
		end else if (len_write) begin
			cell_vld_q <= '0;
		end else if (cmd.step) begin
			cell_vld_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= a_char;
			len_q <= len_clamped;
			idx_q <= '0;
		end else if (cmd.step) begin
			idx_q  <= idx_q + 1'b1;
			left_q <= cell_new;
			diag_q <= above;
			if (idx_q == '0) begin
				sat_q <= (cell_new == CELL_MAX);
			end else begin
				sat_q <= sat_q || (cell_new == CELL_MAX);
			end
		end
	end

	assign left_wide = WIDE_W'(left_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (left_wide > WIDE_W'({DIST_BITS{1'b1}})) begin
				distance_q <= {DIST_BITS{1'b1}};
			end else begin
				distance_q <= left_wide[DIST_BITS-1:0];
			end
			saturated_q <= sat_q;
		end
	end

	assign distance  = distance_q;
	assign saturated = saturated_q;

endmodule

`default_nettype wire

@@ rtl/levenshtein_row_update_core.sv @@
// Top level of the Levenshtein row update block.
//
// Each transfer on in_ch brings one character of string A. The block updates
// its stored Levenshtein row against string B, which is held in the b_length,
// b_chars_low and b_chars_high registers written through cfg_we, cfg_index and
// cfg_data, and gives one transfer on out_ch with the edit distance between the
// A prefix so far and all of B, plus a flag that is set when a cell saturated.
// The row is swept one cell per cycle, cells 0 to L, where L is the active
// length of B (at most MAX_B_LEN), through the row memory with its registered
// read port, and the result is then loaded into the output register. A new
// character is accepted only when the block is idle again, once the result of
// the last one has been loaded into the output register.
// After reset the configuration registers are zero and the row holds cell j = j;
// a write to b_length restores that row at once. When the receiver stalls, the
// result is held in the output register while the next character is accepted
// and swept; the next result then waits until the output register is free.
`default_nettype none

module levenshtein_row_update_core #(
	parameter int MAX_B_LEN = lev_pkg::DEF_MAX_B_LEN,
	parameter int CELL_BITS = lev_pkg::DEF_CELL_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [lev_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [lev_pkg::CFG_DATA_BITS-1:0] cfg_data,
	lev_in_if.sink                                 in_ch,
	lev_out_if.source                              out_ch
);
	import lev_pkg::*;

	lev_cmd_t cmd;
	lev_sts_t sts;

	lev_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lev_dpath #(
		.MAX_B_LEN (MAX_B_LEN),
		.CELL_BITS (CELL_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.a_char    (in_ch.a_char),
		.cmd       (cmd),
		.sts       (sts),
		.distance  (out_ch.distance),
		.saturated (out_ch.saturated)
	);

endmodule

`default_nettype wire
